// ===== hdl/ffha_pkg.sv =====
// ffha_pkg: shared types and constants of the first-fit heap allocator
// no dependencies
package ffha_pkg;

  localparam int HEAP_BYTES   = 67108864;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 256;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int OFF_W        = 26;
  localparam int SIZE_W       = 27;
  localparam int MIN_SPLIT    = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  payload_offset_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  payload_offset;
    logic [SIZE_W-1:0] bytes_left;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    logic              is_free;
    logic              reject;
    logic [1:0]        rej_status;
    logic [SIZE_W-1:0] need;
    logic [OFF_W-1:0]  offset;
  } job_t;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] size;
    logic             used;
  } entry_t;

endpackage

// ===== hdl/ffha_front.sv =====
// ffha_front: accepts commands, rounds sizes and flags early rejections
// depends on ffha_pkg; free byte count is supplied by the back end
module ffha_front import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cmd_t              cmd,
  input  logic [SIZE_W-1:0] free_bytes,
  output logic              in_ready,
  output logic              q_valid,
  output job_t              q_job,
  input  logic              q_ready
);

  job_t              job_next;
  logic [SIZE_W-1:0] req_m1;

  assign in_ready = !q_valid;
  assign req_m1   = cmd.request_size - SIZE_W'(1);

  always_comb begin
    job_next = '0;
    job_next.is_free = (cmd.opcode == OP_FREE);
    job_next.offset  = cmd.payload_offset_in;
    job_next.need    = (req_m1 | SIZE_W'(15)) + SIZE_W'(1);
    if (cmd.opcode == OP_FREE) begin
      if (free_bytes >= SIZE_W'(HEAP_BYTES)) begin
        job_next.reject = 1'b1;
        job_next.rej_status = ST_NONE;
      end
    end else if (cmd.request_size == '0 || free_bytes < cmd.request_size) begin
      job_next.reject = 1'b1;
      job_next.rej_status = ST_NOFIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
      q_job <= job_next;
    end else if (q_ready) begin
      q_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/ffha_back.sv =====
// ffha_back: walks and edits the block table entry by entry, and takes no new job until the last one is done
// depends on ffha_pkg; table memory sits in this module
module ffha_back import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_ready,
  output logic [SIZE_W-1:0] free_bytes,
  output logic              done,
  output result_t           res
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_SCAN, S_OPEN, S_SPLIT, S_FRD, S_FNEXT,
    S_FPREV, S_DROP, S_DONE
  } state_t;

  state_t           state;
  entry_t           mem [MAX_BLOCKS];
  entry_t           rdata;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  job_t             job;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] hit;
  logic [CNT_W-1:0] dst;
  entry_t           cur;
  entry_t           prev;
  entry_t           split_e;
  logic             has_prev;
  logic             cur_valid;
  logic [1:0]       status;
  logic [OFF_W-1:0] pay;
  logic [SIZE_W:0]  need_hdr;
  logic             fits;
  logic             can_split;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign q_ready   = (state == S_IDLE);
  assign need_hdr  = {1'b0, job.need} + (SIZE_W+1)'(HEADER_BYTES + MIN_SPLIT);
  assign fits      = !rdata.used && ({1'b0, rdata.size} >= job.need);
  assign can_split = ({2'b0, rdata.size} >= need_hdr) && (count < CNT_W'(MAX_BLOCKS));

  always_ff @(posedge clk) begin
    we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      count <= CNT_W'(1);
      free_bytes <= SIZE_W'(HEAP_BYTES);
    end else begin
      unique case (state)
        S_INIT: begin
          we <= 1'b1;
          waddr <= '0;
          wdata <= '{start: '0, size: OFF_W'(HEAP_BYTES - HEADER_BYTES), used: 1'b0};
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            job <= q_job;
            status <= ST_OK;
            pay <= '0;
            idx <= '0;
            raddr <= '0;
            has_prev <= 1'b0;
            cur_valid <= 1'b0;
            if (q_job.reject) begin
              status <= q_job.rej_status;
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= job.is_free ? S_FRD : S_SCAN;
        end
        S_SCAN: begin
          if (idx >= count) begin
            status <= ST_NOFIT;
            state <= S_DONE;
          end else if (fits) begin
            hit <= idx;
            pay <= rdata.start + OFF_W'(HEADER_BYTES);
            we <= 1'b1;
            waddr <= idx[IDX_W-1:0];
            if (can_split) begin
              wdata <= '{start: rdata.start, size: job.need[OFF_W-1:0], used: 1'b1};
              split_e <= '{start: rdata.start + OFF_W'(HEADER_BYTES) + job.need[OFF_W-1:0],
                           size: rdata.size - job.need[OFF_W-1:0] - OFF_W'(HEADER_BYTES),
                           used: 1'b0};
              free_bytes <= free_bytes - job.need - SIZE_W'(HEADER_BYTES);
              dst <= count;
              raddr <= IDX_W'(count - CNT_W'(1));
              state <= S_OPEN;
            end else begin
              wdata <= '{start: rdata.start, size: rdata.size, used: 1'b1};
              free_bytes <= free_bytes - {1'b0, rdata.size};
              state <= S_DONE;
            end
          end else begin
            idx <= idx + CNT_W'(1);
            raddr <= IDX_W'(idx + CNT_W'(1));
            state <= S_RD;
          end
        end
        // shift entries above the hit up by one, high end first, then write the split remainder
        S_OPEN: begin
          if (dst == hit + CNT_W'(1)) begin
            we <= 1'b1;
            waddr <= IDX_W'(dst);
            wdata <= split_e;
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          we <= 1'b1;
          waddr <= IDX_W'(dst);
          wdata <= rdata;
          dst <= dst - CNT_W'(1);
          raddr <= IDX_W'(dst - CNT_W'(2));
          state <= S_OPEN;
        end
        S_FRD: begin
          if (idx >= count) begin
            status <= ST_UNKNOWN;
            state <= S_DONE;
          end else if (rdata.start + OFF_W'(HEADER_BYTES) == job.offset) begin
            if (!rdata.used) begin
              status <= ST_UNKNOWN;
              state <= S_DONE;
            end else begin
              hit <= idx;
              cur <= '{start: rdata.start, size: rdata.size, used: 1'b0};
              free_bytes <= free_bytes + {1'b0, rdata.size};
              raddr <= IDX_W'(idx + CNT_W'(1));
              state <= S_FNEXT;
            end
          end else begin
            prev <= rdata;
            has_prev <= 1'b1;
            idx <= idx + CNT_W'(1);
            raddr <= IDX_W'(idx + CNT_W'(1));
            state <= S_RD;
          end
        end
        S_FNEXT: begin
          cur_valid <= 1'b1;
          state <= S_FPREV;
        end
        S_FPREV: begin
          we <= 1'b1;
          if (hit + CNT_W'(1) < count && !rdata.used && cur_valid) begin
            cur.size <= cur.size + OFF_W'(HEADER_BYTES) + rdata.size;
            free_bytes <= free_bytes + SIZE_W'(HEADER_BYTES);
            waddr <= hit[IDX_W-1:0];
            wdata <= '{start: cur.start, size: cur.size + OFF_W'(HEADER_BYTES) + rdata.size,
                       used: 1'b0};
            dst <= hit + CNT_W'(1);
            cur_valid <= 1'b0;
            count <= count - CNT_W'(1);
            raddr <= IDX_W'(hit + CNT_W'(2));
            state <= S_DROP;
          end else if (has_prev && !prev.used) begin
            waddr <= IDX_W'(hit - CNT_W'(1));
            wdata <= '{start: prev.start, size: prev.size + OFF_W'(HEADER_BYTES) + cur.size,
                       used: 1'b0};
            free_bytes <= free_bytes + SIZE_W'(HEADER_BYTES);
            has_prev <= 1'b0;
            dst <= hit;
            count <= count - CNT_W'(1);
            raddr <= IDX_W'(hit + CNT_W'(1));
            state <= S_DROP;
          end else begin
            waddr <= hit[IDX_W-1:0];
            wdata <= cur;
            state <= S_DONE;
          end
        end
        // close the gap at dst; raddr already points at dst+1; then merge into a free previous entry
        S_DROP: begin
          if (dst >= count) begin
            if (has_prev && !prev.used) begin
              cur_valid <= 1'b0;
              state <= S_FPREV;
            end else begin
              state <= S_DONE;
            end
          end else if (raddr == IDX_W'(dst + CNT_W'(1)) && cur_valid) begin
            we <= 1'b1;
            waddr <= IDX_W'(dst);
            wdata <= rdata;
            dst <= dst + CNT_W'(1);
            raddr <= IDX_W'(dst + CNT_W'(2));
            cur_valid <= 1'b0;
          end else begin
            cur_valid <= 1'b1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          res <= '{status: status, payload_offset: pay, bytes_left: free_bytes};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(1) && count <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");
  a_free_cap: assert property (@(posedge clk) disable iff (rst)
    free_bytes <= SIZE_W'(HEAP_BYTES))
    else $error("free bytes above heap size");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result outside idle");

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: top level joining front end, queue and back end
// depends on ffha_pkg, ffha_front, ffha_back
//
//  channel   ports                  transfer
//  command   start, busy, cmd       start && !busy
//  result    done, res              done (one cycle, no stall)
//
// an allocate scans table entries one at a time, then moves entries up one slot
// on a split; a free likewise scans then moves entries on merges;
// the table walk, up to MAX_BLOCKS entries, sets the time per command
// after reset the back end writes the initial block in state S_INIT before it takes commands
// the receiver cannot stall; busy is high from a transfer until its result
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t res
);

  logic              q_valid;
  logic              q_ready;
  logic              in_ready;
  job_t              q_job;
  logic [SIZE_W-1:0] free_bytes;
  logic              pend;

  // one command in flight at a time so the free count seen by the front is current
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else if (start && !busy) pend <= 1'b1;
    else if (done) pend <= 1'b0;
  end

  assign busy = pend || !in_ready;

  ffha_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !pend), .cmd(cmd),
    .free_bytes(free_bytes), .in_ready(in_ready),
    .q_valid(q_valid), .q_job(q_job), .q_ready(q_ready)
  );

  ffha_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_job(q_job), .q_ready(q_ready),
    .free_bytes(free_bytes), .done(done), .res(res)
  );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of first_fit_heap_allocator
// predicts each result with a behavioral block-table model held in a scoreboard class
// depends on ffha_pkg and the first_fit_heap_allocator rtl
module tb_top;
  import ffha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class heap_scoreboard;
    entry_t tbl[MAX_BLOCKS];
    int unsigned nblk;
    longint unsigned free_bytes;
    result_t pending[$];
    int unsigned errors;
    logic [OFF_W-1:0] live[$];

    function new();
      nblk = 1;
      free_bytes = HEAP_BYTES;
      tbl[0].start = '0;
      tbl[0].size = OFF_W'(HEAP_BYTES - HEADER_BYTES);
      tbl[0].used = 1'b0;
      errors = 0;
    endfunction

    function void remove_at(int unsigned idx);
      for (int unsigned k = idx; k + 1 < nblk; k++) tbl[k] = tbl[k + 1];
      nblk--;
    endfunction

    function status_t allocate(longint unsigned req, ref logic [OFF_W-1:0] off);
      longint unsigned need;
      if (req == 0 || free_bytes < req) return ST_NOFIT;
      need = ((req - 1) | 15) + 1;
      for (int unsigned i = 0; i < nblk; i++) begin
        if (tbl[i].used || longint'(tbl[i].size) < need) continue;
        tbl[i].used = 1'b1;
        if (longint'(tbl[i].size) >= need + HEADER_BYTES + MIN_SPLIT && nblk < MAX_BLOCKS) begin
          for (int unsigned k = nblk; k > i + 1; k--) tbl[k] = tbl[k - 1];
          nblk++;
          tbl[i + 1].start = OFF_W'(tbl[i].start + HEADER_BYTES + need);
          tbl[i + 1].size = OFF_W'(tbl[i].size - need - HEADER_BYTES);
          tbl[i + 1].used = 1'b0;
          free_bytes -= HEADER_BYTES;
          tbl[i].size = OFF_W'(need);
        end else begin
          need = tbl[i].size;
        end
        free_bytes -= need;
        off = OFF_W'(tbl[i].start + HEADER_BYTES);
        return ST_OK;
      end
      return ST_NOFIT;
    endfunction

    function status_t release_block(logic [OFF_W-1:0] off);
      int idx;
      idx = -1;
      if (free_bytes >= HEAP_BYTES) return ST_NONE;
      for (int unsigned i = 0; i < nblk; i++)
        if (longint'(tbl[i].start) + HEADER_BYTES == longint'(off)) begin
          idx = i;
          break;
        end
      if (idx < 0 || !tbl[idx].used) return ST_UNKNOWN;
      tbl[idx].used = 1'b0;
      free_bytes += tbl[idx].size;
      if (idx + 1 < nblk && !tbl[idx + 1].used) begin
        tbl[idx].size = OFF_W'(tbl[idx].size + HEADER_BYTES + tbl[idx + 1].size);
        free_bytes += HEADER_BYTES;
        remove_at(idx + 1);
      end
      if (idx > 0 && !tbl[idx - 1].used) begin
        tbl[idx - 1].size = OFF_W'(tbl[idx - 1].size + HEADER_BYTES + tbl[idx].size);
        free_bytes += HEADER_BYTES;
        remove_at(idx);
      end
      return ST_OK;
    endfunction

    function void note_command(cmd_t c);
      result_t r;
      logic [OFF_W-1:0] off;
      off = '0;
      if (c.opcode == OP_ALLOC) begin
        r.status = allocate(c.request_size, off);
        if (r.status == ST_OK) live.push_back(off);
      end else begin
        r.status = release_block(c.payload_offset_in);
        if (r.status == ST_OK)
          foreach (live[j]) if (live[j] == c.payload_offset_in) begin
            live.delete(j);
            break;
          end
      end
      r.payload_offset = off;
      r.bytes_left = free_bytes[SIZE_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.payload_offset !== exp.payload_offset) begin
        $error("payload_offset exp %0d got %0d", exp.payload_offset, got.payload_offset);
        errors++;
      end
      if (got.bytes_left !== exp.bytes_left) begin
        $error("bytes_left exp %0d got %0d", exp.bytes_left, got.bytes_left);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  cmd_t cmd;
  result_t res;
  heap_scoreboard sb;
  int gap_pct;

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk)
    if (!rst && done) sb.check_result(res);

  // one transfer; start stays high when items follow back to back
  task automatic send(cmd_t c);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic do_alloc(logic [SIZE_W-1:0] sz);
    cmd_t c;
    c.opcode = OP_ALLOC;
    c.request_size = sz;
    c.payload_offset_in = OFF_W'($urandom);
    send(c);
  endtask

  task automatic do_free(logic [OFF_W-1:0] off);
    cmd_t c;
    c.opcode = OP_FREE;
    c.request_size = SIZE_W'($urandom);
    c.payload_offset_in = off;
    send(c);
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return SIZE_W'($urandom_range(256, 1));
    if (p < 90) return SIZE_W'($urandom_range(1 << 16, 1));
    if (p < 97) return SIZE_W'($urandom_range(1 << 22, 1));
    return SIZE_W'($urandom_range(HEAP_BYTES, 0));
  endfunction

  task automatic random_phase(int n);
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (sb.live.size() > 0 && (p < 40 || sb.live.size() > 200))
        do_free(sb.live[$urandom_range(sb.live.size() - 1)]);
      else if (p < 45)
        do_free(OFF_W'($urandom));
      else if (p < 48 && sb.live.size() > 0)
        do_free(sb.live[$urandom_range(sb.live.size() - 1)] + OFF_W'(16));
      else
        do_alloc(rand_size());
    end
  endtask

  initial begin
    logic [OFF_W-1:0] a, b, c3;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    gap_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty heap, bad sizes, extremes, merges
    do_free(OFF_W'(HEADER_BYTES));
    do_alloc(SIZE_W'(0));
    do_alloc(SIZE_W'(HEAP_BYTES));
    do_alloc({SIZE_W{1'b1}});
    do_alloc(SIZE_W'(1));
    do_alloc(SIZE_W'(16));
    do_alloc(SIZE_W'(17));
    do_free(OFF_W'(0));
    do_free({OFF_W{1'b1}});
    a = sb.live[0];
    b = sb.live[1];
    c3 = sb.live[2];
    do_free(b);
    do_free(b);
    do_free(a);
    do_free(c3);
    do_alloc(SIZE_W'(HEAP_BYTES - HEADER_BYTES));
    do_free(OFF_W'(HEADER_BYTES));
    do_alloc(SIZE_W'(HEAP_BYTES - 2 * HEADER_BYTES - 16));
    do_alloc(SIZE_W'(HEAP_BYTES - 3 * HEADER_BYTES - 32));
    while (sb.live.size() > 0) do_free(sb.live.pop_back());
    do_alloc(SIZE_W'(40));
    do_alloc(SIZE_W'(HEAP_BYTES - HEADER_BYTES - 48 - HEADER_BYTES - 16));
    while (sb.live.size() > 0) do_free(sb.live[0]);
    // table full: fill with small blocks
    for (int i = 0; i < MAX_BLOCKS + 4; i++) do_alloc(SIZE_W'(16));
    for (int i = 0; i < 40; i++) do_free(sb.live[$urandom_range(sb.live.size() - 1)]);
    while (sb.live.size() > 0) do_free(sb.live.pop_front());

    gap_pct = 27;
    random_phase(250);
    gap_pct = 66;
    random_phase(250);
    gap_pct = 0;
    random_phase(250);

    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
